// ----- rtl/tcsw_pkg.sv -----
package tcsw_pkg;

    // Widths of the item fields on the ports.
    localparam int REQ_TYPE_W   = 1;
    localparam int CHAR_W       = 8;
    localparam int VIEW_ROW_W   = 5;
    localparam int VIEW_COL_W   = 7;
    localparam int CELL_W       = 16;
    localparam int CURSOR_W     = 11;
    localparam int TOP_LINE_W   = 5;
    localparam int ATTR_W       = 8;

    // Request codes and special characters.
    localparam logic [REQ_TYPE_W-1:0] REQ_WRITE    = 1'b0;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ     = 1'b1;
    localparam logic [CHAR_W-1:0]     NEWLINE_CODE = 8'd10;
    localparam logic [ATTR_W-1:0]     ATTR_RESET   = 8'd15;

    // Controller states, one-hot.
    typedef enum logic [7:0] {
        ST_CLEAR    = 8'b0000_0001,
        ST_IDLE     = 8'b0000_0010,
        ST_RD_ROW   = 8'b0000_0100,
        ST_RD_ISSUE = 8'b0000_1000,
        ST_WRITE    = 8'b0001_0000,
        ST_LINE_END = 8'b0010_0000,
        ST_BLANK    = 8'b0100_0000,
        ST_FIN      = 8'b1000_0000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic rd_row;
        logic rd_issue;
        logic wr_cell;
        logic line_end;
        logic blank_wr;
        logic load_result;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_read;
        logic is_newline;
        logic col_last;
        logic blank_last;
        logic clear_last;
    } t_dp_sts;

endpackage

// ----- rtl/tcsw_ram.sv -----
module tcsw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tcsw_ctrl.sv -----
module tcsw_ctrl
    import tcsw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.blank_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_sts.in_read ? ST_RD_ROW : ST_WRITE;
                end
            end
            ST_RD_ROW: begin
                o_cmd.rd_row = 1'b1;
                n_state = ST_RD_ISSUE;
            end
            ST_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state = ST_FIN;
            end
            ST_WRITE: begin
                o_cmd.wr_cell = 1'b1;
                if (i_sts.col_last) begin
                    n_state = ST_LINE_END;
                end else if (i_sts.is_newline) begin
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_LINE_END: begin
                o_cmd.line_end = 1'b1;
                n_state = ST_BLANK;
            end
            ST_BLANK: begin
                o_cmd.blank_wr = 1'b1;
                if (i_sts.blank_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_ready) begin
                    o_cmd.load_result = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register and output slot occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;

    // A transfer in always starts either the read or the write sequence.
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid) |=> (r_state == ST_RD_ROW || r_state == ST_WRITE))
        else $error("transfer did not start a sequence");

endmodule

// ----- rtl/tcsw_dp.sv -----
module tcsw_dp
    import tcsw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_we,
    input  logic [ATTR_W-1:0]     i_cfg_data,
    input  logic [REQ_TYPE_W-1:0] i_req_type,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [VIEW_ROW_W-1:0] i_view_row,
    input  logic [VIEW_COL_W-1:0] i_view_col,
    output logic [CELL_W-1:0]     o_cell_data,
    output logic [CURSOR_W-1:0]   o_cursor_index,
    output logic [TOP_LINE_W-1:0] o_top_line
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CURW  = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int SW    = $clog2(ROWS);
    localparam int CLW   = $clog2(COLUMNS + 1);
    localparam int SUMW  = ((VIEW_ROW_W > SW) ? VIEW_ROW_W : SW) + 1;

    // Cursor kept both as a linear index and as row and column.
    logic [CURW-1:0]   r_cursor, n_cursor;
    logic [RW-1:0]     r_row, n_row;
    logic [CLW-1:0]    r_col, n_col;
    logic [SW-1:0]     r_scroll, n_scroll;
    logic              r_wrapped, n_wrapped;
    logic [AW-1:0]     r_baddr, n_baddr;
    logic [CLW-1:0]    r_bcnt, n_bcnt;
    logic [ATTR_W-1:0] r_char_attribute;

    // Captured item and read pipeline.
    logic [REQ_TYPE_W-1:0] r_req;
    logic [CHAR_W-1:0]     r_code;
    logic [VIEW_ROW_W-1:0] r_vrow;
    logic [VIEW_COL_W-1:0] r_vcol;
    logic [SW-1:0]         r_srow;
    logic [CLW-1:0]        r_rcol;
    logic                  r_rd_ok;
    logic [CELL_W-1:0]     r_out_cell;
    logic [CURSOR_W-1:0]   r_out_cursor;
    logic [TOP_LINE_W-1:0] r_out_top;

    logic [SUMW-1:0]   rd_sum;
    logic [SUMW-1:0]   rd_wrap;
    logic              rd_ok;
    logic [AW-1:0]     rd_addr;
    logic [CELL_W-1:0] rd_data;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              row_over;

    // Status toward the controller.
    assign o_sts.in_read    = (i_req_type == REQ_READ);
    assign o_sts.is_newline = (r_code == NEWLINE_CODE);
    assign o_sts.col_last   = (r_col == CLW'(COLUMNS - 1));
    assign o_sts.blank_last = (r_bcnt == CLW'(COLUMNS - 1));
    assign o_sts.clear_last = (r_baddr == AW'(CELLS - 1));

    assign row_over = (r_row == RW'(ROWS));

    // Cursor, scroll and sweep counter updates.
    always_comb begin
        n_cursor  = r_cursor;
        n_row     = r_row;
        n_col     = r_col;
        n_scroll  = r_scroll;
        n_wrapped = r_wrapped;
        n_baddr   = r_baddr;
        n_bcnt    = r_bcnt;
        if (i_cmd.wr_cell) begin
            n_cursor = r_cursor + 1'b1;
            if (o_sts.col_last) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (i_cmd.line_end) begin
            if (r_wrapped) begin
                n_scroll = (r_scroll == SW'(ROWS - 1)) ? '0 : r_scroll + 1'b1;
            end
            if (row_over) begin
                n_wrapped = 1'b1;
                n_cursor  = '0;
                n_row     = '0;
                n_col     = '0;
                n_scroll  = SW'(1);
                n_baddr   = '0;
            end else begin
                n_baddr = r_cursor[AW-1:0];
            end
            n_bcnt = '0;
        end
        if (i_cmd.blank_wr) begin
            n_baddr = r_baddr + 1'b1;
            n_bcnt  = r_bcnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor         <= '0;
            r_row            <= '0;
            r_col            <= '0;
            r_scroll         <= '0;
            r_wrapped        <= 1'b0;
            r_baddr          <= '0;
            r_bcnt           <= '0;
            r_char_attribute <= ATTR_RESET;
        end else begin
            r_cursor  <= n_cursor;
            r_row     <= n_row;
            r_col     <= n_col;
            r_scroll  <= n_scroll;
            r_wrapped <= n_wrapped;
            r_baddr   <= n_baddr;
            r_bcnt    <= n_bcnt;
            if (i_cfg_we) begin
                r_char_attribute <= i_cfg_data;
            end
        end
    end

    // Displayed row to store row, with the range check.
    assign rd_sum  = SUMW'(r_vrow) + SUMW'(r_scroll);
    assign rd_wrap = (rd_sum >= SUMW'(ROWS)) ? rd_sum - SUMW'(ROWS) : rd_sum;
    assign rd_ok   = (r_vrow < ROWS) && (r_vcol < COLUMNS);
    assign rd_addr = AW'(r_srow * COLUMNS + r_rcol);

    // Item capture, read pipeline and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_code <= i_char_code;
            r_vrow <= i_view_row;
            r_vcol <= i_view_col;
        end
        if (i_cmd.rd_row) begin
            r_rd_ok <= rd_ok;
            r_srow  <= rd_ok ? SW'(rd_wrap) : '0;
            r_rcol  <= rd_ok ? CLW'(r_vcol) : '0;
        end
        if (i_cmd.load_result) begin
            r_out_cell   <= (r_req == REQ_READ && r_rd_ok) ? rd_data : '0;
            r_out_cursor <= CURSOR_W'(r_cursor);
            r_out_top    <= TOP_LINE_W'(r_scroll);
        end
    end

    // Write port: character or blank at the cursor, or zero at the sweep address.
    assign ram_we    = i_cmd.wr_cell | i_cmd.blank_wr;
    assign ram_waddr = i_cmd.wr_cell ? r_cursor[AW-1:0] : r_baddr;
    assign ram_wdata = (i_cmd.wr_cell && !o_sts.is_newline) ? {r_char_attribute, r_code}
                                                             : '0;

    tcsw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign o_cell_data    = r_out_cell;
    assign o_cursor_index = r_out_cursor;
    assign o_top_line     = r_out_top;

    // The linear cursor always matches its row and column.
    a_cursor_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor == CURW'(r_row * COLUMNS + r_col))
        else $error("cursor index and row/column disagree");

    // The top line always names a stored row.
    a_scroll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scroll < ROWS)
        else $error("scroll offset out of range");

    // A character is never written past the last cell.
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_cell |-> (r_cursor < CELLS))
        else $error("cell write past end of store");

endmodule

// ----- rtl/text_console_scroll_writer.sv -----
// A read captures the item, maps the row, reads the cell memory and loads the result;
// a plain character is written before its result is loaded. A newline writes the rest
// of the line one cell a cycle, and every line end then blanks the next row.
// Throughput: one item at a time; the next transfer in is taken when the sequence ends.
// Reset: synchronous, active low; afterwards ready stays low while all COLUMNS*ROWS cells
// (2000 by default) are cleared.
module text_console_scroll_writer
    import tcsw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [ATTR_W-1:0]     i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [REQ_TYPE_W-1:0] i_req_type,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [VIEW_ROW_W-1:0] i_view_row,
    input  logic [VIEW_COL_W-1:0] i_view_col,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CELL_W-1:0]     o_cell_data,
    output logic [CURSOR_W-1:0]   o_cursor_index,
    output logic [TOP_LINE_W-1:0] o_top_line
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    tcsw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Cursor, scroll, cell store and result register.
    tcsw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_req_type     (i_req_type),
        .i_char_code    (i_char_code),
        .i_view_row     (i_view_row),
        .i_view_col     (i_view_col),
        .o_cell_data    (o_cell_data),
        .o_cursor_index (o_cursor_index),
        .o_top_line     (o_top_line)
    );

endmodule
